// ===== design/dpb_pkg.sv =====
// ----------------------------------------------------------------------------
// dpb_pkg: shared types and constants for depth pixel back-projection
// Register indexes, field widths and the word that flows down the divider.
// ----------------------------------------------------------------------------
package dpb_pkg;

    localparam int REG_W   = 16;
    localparam int DEPTH_W = 16;
    localparam int COLOR_W = 8;
    localparam int POS_W   = 32;
    // |numerator| < 2^20 * 2^16 * 2^4 = 2^40 with sixteen coordinate bits
    localparam int MAG_W   = 40;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_FOCAL_X  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FOCAL_Y  = 2'd1;
    localparam logic [IDX_W-1:0] REG_CENTER_X = 2'd2;
    localparam logic [IDX_W-1:0] REG_CENTER_Y = 2'd3;

    localparam logic [REG_W-1:0] FOCAL_X_RST  = 16'd8400;
    localparam logic [REG_W-1:0] FOCAL_Y_RST  = 16'd8400;
    localparam logic [REG_W-1:0] CENTER_X_RST = 16'd5112;
    localparam logic [REG_W-1:0] CENTER_Y_RST = 16'd3832;

    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    // one axis in flight through the restoring divider
    typedef struct packed {
        logic [MAG_W-1:0] rem;     // partial remainder
        logic [MAG_W-1:0] quo;     // numerator bits shifted out, quotient in
        logic [REG_W-1:0] den;
        logic             neg;
        logic             nz;      // numerator nonzero
    } t_div;

endpackage

// ===== design/depth_pixel_backprojection.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_backprojection: pinhole back-projection of depth pixels
// Turns column, row and depth into X, Y, Z with the colour carried along.
// ----------------------------------------------------------------------------
// One pixel word is taken every clock (busy stays low); each word with nonzero
// depth is shown on o_valid after passing the offset, multiply, divider and
// output registers; zero-depth words give nothing. The pipeline is the
// restoring divider, one quotient bit per stage over a 40-bit numerator, plus
// offset, multiply and output stages. The receiver cannot stall; results are
// shown for one cycle only.
module depth_pixel_backprojection #(
    parameter int COORD_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic [COORD_BITS-1:0] i_pixel_column,
    input  logic [COORD_BITS-1:0] i_pixel_row,
    input  logic [15:0] i_depth_mm,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    output logic        o_valid,
    output logic signed [31:0] o_x_position,
    output logic signed [31:0] o_y_position,
    output logic [15:0] o_z_position,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out
);
    localparam int LAT = dpb_pkg::MAG_W + 3;

    logic [15:0] r_focal_x, r_focal_y, r_center_x, r_center_y;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= dpb_pkg::FOCAL_X_RST;
            r_focal_y  <= dpb_pkg::FOCAL_Y_RST;
            r_center_x <= dpb_pkg::CENTER_X_RST;
            r_center_y <= dpb_pkg::CENTER_Y_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dpb_pkg::REG_FOCAL_X:  r_focal_x  <= i_cfg_data;
                dpb_pkg::REG_FOCAL_Y:  r_focal_y  <= i_cfg_data;
                dpb_pkg::REG_CENTER_X: r_center_x <= i_cfg_data;
                dpb_pkg::REG_CENTER_Y: r_center_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    dpb_axis #(.COORD_BITS(COORD_BITS)) u_x (
        .i_clk(i_clk), .i_coord(i_pixel_column), .i_center(r_center_x),
        .i_focal(r_focal_x), .i_depth(i_depth_mm), .o_pos(o_x_position));

    dpb_axis #(.COORD_BITS(COORD_BITS)) u_y (
        .i_clk(i_clk), .i_coord(i_pixel_row), .i_center(r_center_y),
        .i_focal(r_focal_y), .i_depth(i_depth_mm), .o_pos(o_y_position));

    // valid and pass-through fields follow the divider latency
    logic        r_vld [0:LAT-1];
    logic [39:0] r_pay [0:LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_vld[i] <= 1'b0;
        end else begin
            r_vld[0] <= start && (i_depth_mm != '0);
            for (int i = 1; i < LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pay[0] <= {i_depth_mm, i_red_in, i_green_in, i_blue_in};
        for (int i = 1; i < LAT; i++) r_pay[i] <= r_pay[i-1];
    end

    assign o_valid      = r_vld[LAT-1];
    assign o_z_position = r_pay[LAT-1][39:24];
    assign o_red_out    = r_pay[LAT-1][23:16];
    assign o_green_out  = r_pay[LAT-1][15:8];
    assign o_blue_out   = r_pay[LAT-1][7:0];

endmodule

// ===== design/dpb_axis.sv =====
// ----------------------------------------------------------------------------
// dpb_axis: one projection axis
// (16*coord - center) * depth * 16 / focal, truncated, saturated to 32 bits.
// Stage 1 offset, stage 2 multiply, then one quotient bit per stage, then a final sign and saturate stage.
// ----------------------------------------------------------------------------
module dpb_axis #(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic [COORD_BITS-1:0]        i_coord,
    input  logic [dpb_pkg::REG_W-1:0]    i_center,
    input  logic [dpb_pkg::REG_W-1:0]    i_focal,
    input  logic [dpb_pkg::DEPTH_W-1:0]  i_depth,
    output logic signed [dpb_pkg::POS_W-1:0] o_pos
);
    localparam int MW  = dpb_pkg::MAG_W;
    localparam int RW  = dpb_pkg::REG_W;
    // signed offset: wider of 16*coord and center, plus a sign bit
    localparam int OFW = ((COORD_BITS + 4 > RW) ? COORD_BITS + 4 : RW) + 1;
    localparam int PW  = OFW - 1 + dpb_pkg::DEPTH_W;   // magnitude product
    localparam int NST = MW;   // one quotient bit per stage

    // stage 1: offset magnitude and sign
    logic signed [OFW-1:0] n_off;
    logic [OFW-2:0]        r_offm;
    logic                  r_neg1;
    logic [RW-1:0]         r_den1;
    logic [dpb_pkg::DEPTH_W-1:0] r_dep1;

    assign n_off = $signed({{(OFW-COORD_BITS-4){1'b0}}, i_coord, 4'b0})
                 - $signed({{(OFW-RW){1'b0}}, i_center});

    always_ff @(posedge i_clk) begin
        r_neg1 <= n_off[OFW-1];
        r_offm <= n_off[OFW-1] ? (OFW-1)'(-n_off) : (OFW-1)'(n_off);
        r_den1 <= i_focal;
        r_dep1 <= i_depth;
    end

    // stage 2: magnitude product times 16
    dpb_pkg::t_div r_st [0:NST];
    logic [PW-1:0] n_mul;
    logic [MW-1:0] n_prod;
    assign n_mul  = PW'(r_offm) * PW'(r_dep1);
    assign n_prod = MW'({n_mul, 4'b0});

    always_ff @(posedge i_clk) begin
        r_st[0].rem <= '0;
        r_st[0].quo <= n_prod;
        r_st[0].den <= r_den1;
        r_st[0].neg <= r_neg1;
        r_st[0].nz  <= (n_prod != '0);
    end

    // divider stages: shift one numerator bit into the remainder each stage
    for (genvar g = 0; g < NST; g++) begin : g_div
        logic [MW:0] n_sh;
        logic [MW:0] n_df;
        assign n_sh = {r_st[g].rem, r_st[g].quo[MW-1]};
        assign n_df = n_sh - {{(MW+1-RW){1'b0}}, r_st[g].den};
        always_ff @(posedge i_clk) begin
            r_st[g+1].den <= r_st[g].den;
            r_st[g+1].neg <= r_st[g].neg;
            r_st[g+1].nz  <= r_st[g].nz;
            if (!n_df[MW]) begin
                r_st[g+1].rem <= n_df[MW-1:0];
                r_st[g+1].quo <= {r_st[g].quo[MW-2:0], 1'b1};
            end else begin
                r_st[g+1].rem <= n_sh[MW-1:0];
                r_st[g+1].quo <= {r_st[g].quo[MW-2:0], 1'b0};
            end
        end
    end

    // final stage: sign, saturate; zero focal yields all-ones quotient
    logic [MW-1:0] w_q;
    logic          w_big;
    assign w_q   = r_st[NST].quo;
    assign w_big = (w_q[MW-1:dpb_pkg::POS_W-1] != '0);

    always_ff @(posedge i_clk) begin
        if (!r_st[NST].nz)
            o_pos <= '0;
        else if (r_st[NST].neg) begin
            if (w_big)
                o_pos <= dpb_pkg::POS_MIN;
            else
                o_pos <= -$signed({1'b0, w_q[dpb_pkg::POS_W-2:0]});
        end else begin
            if (w_big)
                o_pos <= dpb_pkg::POS_MAX;
            else
                o_pos <= $signed({1'b0, w_q[dpb_pkg::POS_W-2:0]});
        end
    end

endmodule

// ===== tb/tb_depth_pixel_backprojection.sv =====
// ----------------------------------------------------------------------------
// tb_depth_pixel_backprojection: self-checking bench for pixel back-projection
// Drives directed and random pixel words with random idle bursts, predicts
// X/Y/Z and colour for each word with nonzero depth, and compares in order.
// ----------------------------------------------------------------------------
module tb_depth_pixel_backprojection;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB      = 12;
    localparam int LATENCY = 43;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        z;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
    } t_point;

    typedef struct {
        logic [CB-1:0] col;
        logic [CB-1:0] row;
        logic [15:0]   depth;
        logic [7:0]    r;
        logic [7:0]    g;
        logic [7:0]    b;
        bit            known;   // expected point typed in below
        t_point        pt;
    } t_row;

    logic i_clk, i_rst_n, start, busy, i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic [CB-1:0] i_pixel_column, i_pixel_row;
    logic [15:0] i_depth_mm;
    logic [7:0] i_red_in, i_green_in, i_blue_in;
    logic o_valid;
    logic signed [31:0] o_x_position, o_y_position;
    logic [15:0] o_z_position;
    logic [7:0] o_red_out, o_green_out, o_blue_out;

    // shadow of the intrinsics
    logic [15:0] fx, fy, cx, cy;

    t_point point_queue[$];
    int     mismatches;
    bit     quiet;   // no idling in the last part

    depth_pixel_backprojection #(.COORD_BITS(CB)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    // one axis: (16*c - ctr)*d*16/f, truncated and saturated
    function automatic logic signed [31:0] backproject(logic [CB-1:0] c, logic [15:0] ctr,
                                                       logic [15:0] d, logic [15:0] f);
        longint num, q;
        num = (longint'(c) * 16 - longint'(ctr)) * longint'(d) * 16;
        if (f == 0) q = (num > 0) ? 64'sd2147483647 : (num < 0) ? -64'sd2147483648 : 0;
        else begin
            q = num / longint'(f);
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
        end
        return q[31:0];
    endfunction

    function automatic t_point project_pixel(t_row p);
        t_point t;
        t.x = backproject(p.col, cx, p.depth, fx);
        t.y = backproject(p.row, cy, p.depth, fy);
        t.z = p.depth;
        t.r = p.r; t.g = p.g; t.b = p.b;
        return t;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_point got, want;
        if (i_rst_n && o_valid) begin
            got = '{o_x_position, o_y_position, o_z_position,
                    o_red_out, o_green_out, o_blue_out};
            if (point_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: %p", got);
            end else begin
                want = point_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: exp %p got %p", want, got);
                end
            end
        end
    end

    // start drops only while idling, so it never gets two updates in one step
    task automatic idle_burst();
        int n;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 17);
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_pixel(t_row p);
        t_point pt;
        idle_burst();
        start          <= 1'b1;
        i_pixel_column <= p.col;
        i_pixel_row    <= p.row;
        i_depth_mm     <= p.depth;
        i_red_in       <= p.r;
        i_green_in     <= p.g;
        i_blue_in      <= p.b;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (p.depth != 0) begin
            pt = project_pixel(p);
            if (p.known && pt !== p.pt) begin
                mismatches++;
                if (mismatches <= 10) $display("predictor disagrees: %p %p", p.pt, pt);
            end
            point_queue.insert(point_queue.size(), p.known ? p.pt : pt);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (point_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            dpb_pkg::REG_FOCAL_X:  fx = val;
            dpb_pkg::REG_FOCAL_Y:  fy = val;
            dpb_pkg::REG_CENTER_X: cx = val;
            dpb_pkg::REG_CENTER_Y: cy = val;
            default: ;
        endcase
    endtask

    task automatic set_intrinsics(logic [15:0] a, logic [15:0] b,
                                  logic [15:0] c, logic [15:0] d);
        write_reg(dpb_pkg::REG_FOCAL_X, a);
        write_reg(dpb_pkg::REG_FOCAL_Y, b);
        write_reg(dpb_pkg::REG_CENTER_X, c);
        write_reg(dpb_pkg::REG_CENTER_Y, d);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_row rand_pixel();
        t_row p;
        p.col   = CB'($urandom());
        p.row   = CB'($urandom());
        case ($urandom_range(0, 7))
            0:       p.depth = 16'd0;
            1:       p.depth = 16'(16'hFFFF - $urandom_range(0, 3));
            2:       p.depth = 16'($urandom_range(1, 4));
            default: p.depth = 16'($urandom_range(1, 65535));
        endcase
        p.r = 8'($urandom()); p.g = 8'($urandom()); p.b = 8'($urandom());
        p.known = 1'b0;
        p.pt = '0;
        return p;
    endfunction

    initial begin
        t_row dir [6];
        t_row p;
        logic [15:0] f;
        i_rst_n = 1'b0; start = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0;
        i_cfg_data = '0; i_pixel_column = '0; i_pixel_row = '0; i_depth_mm = '0;
        i_red_in = '0; i_green_in = '0; i_blue_in = '0;
        mismatches = 0; quiet = 1'b0;
        fx = dpb_pkg::FOCAL_X_RST; fy = dpb_pkg::FOCAL_Y_RST;
        cx = dpb_pkg::CENTER_X_RST; cy = dpb_pkg::CENTER_Y_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under reset intrinsics; expected points where obvious
        dir[0] = '{12'd0, 12'd0, 16'd0, 8'd1, 8'd2, 8'd3, 1'b0, '0};
        // 16*0-5112 = -5112, *16/8400 = -9 (trunc)
        dir[1] = '{12'd0, 12'd0, 16'd1, 8'd0, 8'd0, 8'd0, 1'b1,
                   '{-32'sd9, -32'sd7, 16'd1, 8'd0, 8'd0, 8'd0}};
        dir[2] = '{12'd4095, 12'd4095, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0};
        dir[3] = '{12'd0, 12'd4095, 16'hFFFF, 8'hAA, 8'h55, 8'h0F, 1'b0, '0};
        dir[4] = '{12'd4095, 12'd0, 16'd1, 8'h55, 8'hAA, 8'hF0, 1'b0, '0};
        dir[5] = '{12'd4095, 12'd4095, 16'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0};
        foreach (dir[i]) send_pixel(dir[i]);
        drain();

        // zero focal: saturation; center matching the pixel gives zero
        set_intrinsics(16'd0, 16'd0, 16'd16, 16'd65535);
        p = rand_pixel(); p.col = 12'd1; p.row = 12'd0; p.depth = 16'd5;
        p.known = 1'b1; p.pt = '{32'sd0, 32'sh8000_0000, 16'd5, p.r, p.g, p.b};
        send_pixel(p);
        p = rand_pixel(); p.col = 12'd2; p.row = 12'd4095; p.depth = 16'd7;
        p.known = 1'b1; p.pt = '{32'sh7FFF_FFFF, 32'sh8000_0000, 16'd7, p.r, p.g, p.b};
        send_pixel(p);
        for (int i = 0; i < 8; i++) send_pixel(rand_pixel());
        drain();

        // smallest legal focal, widest numerator: saturation with nonzero focal
        set_intrinsics(16'd16, 16'd16, 16'd0, 16'd0);
        p = rand_pixel(); p.col = 12'd4095; p.row = 12'd0; p.depth = 16'hFFFF;
        p.known = 1'b1; p.pt = '{32'sh7FFF_FFFF, 32'sd0, 16'hFFFF, p.r, p.g, p.b};
        send_pixel(p);
        for (int i = 0; i < 8; i++) send_pixel(rand_pixel());
        drain();

        // random phases over several intrinsic settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_intrinsics(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
                1: set_intrinsics(dpb_pkg::FOCAL_X_RST, dpb_pkg::FOCAL_Y_RST,
                                  dpb_pkg::CENTER_X_RST, dpb_pkg::CENTER_Y_RST);
                default: begin
                    f = $urandom_range(0, 3) == 0 ? 16'd16 : 16'($urandom_range(16, 65535));
                    set_intrinsics(f, 16'($urandom_range(16, 65535)),
                                   16'($urandom()), 16'($urandom()));
                end
            endcase
            if (ph == 7) quiet = 1'b1;
            for (int i = 0; i < 80; i++) send_pixel(rand_pixel());
            drain();
        end

        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
